@@ hdl/mi3_pkg.sv @@
// Shared constants and types for the 3x3 matrix inverse.
package mi3_pkg;

    localparam int IN_W          = 16;  // port width of one element
    localparam int OUT_W         = 48;  // port width of one inverse entry
    localparam int LANES         = 9;   // entries per matrix
    localparam int DEF_ELEM_BITS = 16;
    localparam int DEF_FRAC_BITS = 16;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

endpackage

@@ hdl/matrix3x3_inverse.sv @@
// Top level of the pipelined 3x3 matrix inverse through the adjugate.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_a11 .. i_a33 (16 bit signed)
//  output   out        o_valid / i_ready    o_inv11 .. o_inv33 (48 bit), o_singular
//
// One item per cycle sustained while the output is not stalled; the restoring
// divider computes one quotient bit per stage.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken, and freezes in place otherwise, so a stall
// drops and repeats nothing. Reset clears only the valid bits and the pipeline's singular flags.
module matrix3x3_inverse #(
    parameter int ELEM_BITS = mi3_pkg::DEF_ELEM_BITS,
    parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mi3_pkg::IN_W-1:0]  i_a11,
    input  logic [mi3_pkg::IN_W-1:0]  i_a12,
    input  logic [mi3_pkg::IN_W-1:0]  i_a13,
    input  logic [mi3_pkg::IN_W-1:0]  i_a21,
    input  logic [mi3_pkg::IN_W-1:0]  i_a22,
    input  logic [mi3_pkg::IN_W-1:0]  i_a23,
    input  logic [mi3_pkg::IN_W-1:0]  i_a31,
    input  logic [mi3_pkg::IN_W-1:0]  i_a32,
    input  logic [mi3_pkg::IN_W-1:0]  i_a33,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mi3_pkg::OUT_W-1:0] o_inv11,
    output logic [mi3_pkg::OUT_W-1:0] o_inv12,
    output logic [mi3_pkg::OUT_W-1:0] o_inv13,
    output logic [mi3_pkg::OUT_W-1:0] o_inv21,
    output logic [mi3_pkg::OUT_W-1:0] o_inv22,
    output logic [mi3_pkg::OUT_W-1:0] o_inv23,
    output logic [mi3_pkg::OUT_W-1:0] o_inv31,
    output logic [mi3_pkg::OUT_W-1:0] o_inv32,
    output logic [mi3_pkg::OUT_W-1:0] o_inv33,
    output logic                      o_singular
);
    import mi3_pkg::*;

    localparam int NW = 2 * ELEM_BITS + 1 + FRAC_BITS;  // dividend / quotient magnitude
    localparam int DW = 3 * ELEM_BITS + 1;              // determinant
    localparam int QW = NW + 1;                         // signed quotient
    localparam int XW = (QW > OUT_W ? QW : OUT_W) + 1;  // clamp compare width

    // clamp limits of the output field
    localparam logic signed [XW-1:0] LIM_MAX = {{(XW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [XW-1:0] LIM_MIN = ~LIM_MAX;

    logic             en;
    logic [IN_W-1:0]  a_in [LANES];
    t_ctl             fr_ctl, dv_ctl;
    logic [NW-1:0]    fr_num [LANES];
    logic             fr_neg [LANES];
    logic [DW-1:0]    fr_den;
    logic [NW-1:0]    dv_quo [LANES];
    logic             dv_neg [LANES];
    logic [OUT_W-1:0] n_inv  [LANES];
    logic [OUT_W-1:0] r_inv  [LANES];
    logic             r_ovalid;
    logic             r_sing;

    // advance whenever the output slot is free or leaving
    assign en      = !r_ovalid || i_ready;
    assign o_ready = en;

    assign a_in[0] = i_a11;
    assign a_in[1] = i_a12;
    assign a_in[2] = i_a13;
    assign a_in[3] = i_a21;
    assign a_in[4] = i_a22;
    assign a_in[5] = i_a23;
    assign a_in[6] = i_a31;
    assign a_in[7] = i_a32;
    assign a_in[8] = i_a33;

    mi3_front #(
        .ELEM_BITS (ELEM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (a_in),
        .o_ctl   (fr_ctl),
        .o_num   (fr_num),
        .o_neg   (fr_neg),
        .o_den   (fr_den)
    );

    mi3_divider #(
        .ELEM_BITS (ELEM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (fr_ctl),
        .i_num   (fr_num),
        .i_neg   (fr_neg),
        .i_den   (fr_den),
        .o_ctl   (dv_ctl),
        .o_quo   (dv_quo),
        .o_neg   (dv_neg)
    );

    // restore sign, clamp to the field, zero for a singular matrix
    always_comb begin
        logic signed [QW-1:0] q;
        logic signed [XW-1:0] x;
        for (int l = 0; l < LANES; l++) begin
            q = dv_neg[l] ? -$signed(QW'(dv_quo[l])) : $signed(QW'(dv_quo[l]));
            x = XW'(q);
            if (x > LIM_MAX) begin
                x = LIM_MAX;
            end else if (x < LIM_MIN) begin
                x = LIM_MIN;
            end
            n_inv[l] = dv_ctl.singular ? '0 : x[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= dv_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing <= dv_ctl.singular;
            for (int l = 0; l < LANES; l++) begin
                r_inv[l] <= n_inv[l];
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_singular = r_sing;
    assign o_inv11    = r_inv[0];
    assign o_inv12    = r_inv[1];
    assign o_inv13    = r_inv[2];
    assign o_inv21    = r_inv[3];
    assign o_inv22    = r_inv[4];
    assign o_inv23    = r_inv[5];
    assign o_inv31    = r_inv[6];
    assign o_inv32    = r_inv[7];
    assign o_inv33    = r_inv[8];

`ifndef SYNTH
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_inv11 == '0) && (o_inv12 == '0) && (o_inv13 == '0)
            && (o_inv21 == '0) && (o_inv22 == '0) && (o_inv23 == '0)
            && (o_inv31 == '0) && (o_inv32 == '0) && (o_inv33 == '0))
        else $error("singular result with non-zero entries");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_ctl.valid && !en |=> dv_ctl.valid)
        else $error("item lost from divider tail during stall");
`endif

endmodule

@@ hdl/mi3_front.sv @@
// Front pipeline: element capture, cofactors, determinant and magnitudes.
module mi3_front #(
    parameter int ELEM_BITS = mi3_pkg::DEF_ELEM_BITS,
    parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS,
    localparam int NW = 2 * ELEM_BITS + 1 + FRAC_BITS,
    localparam int DW = 3 * ELEM_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [mi3_pkg::IN_W-1:0] i_a   [mi3_pkg::LANES],
    output mi3_pkg::t_ctl            o_ctl,
    output logic [NW-1:0]            o_num [mi3_pkg::LANES],
    output logic                     o_neg [mi3_pkg::LANES],
    output logic [DW-1:0]            o_den
);
    import mi3_pkg::*;

    localparam int E  = ELEM_BITS;
    localparam int PW = 2 * ELEM_BITS;
    localparam int CW = 2 * ELEM_BITS + 1;

    // adjugate entry l = m[PA]*m[PB] - m[PC]*m[PD], negated where CNEG
    localparam int PA [LANES] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int PB [LANES] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int PC [LANES] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam int PD [LANES] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam bit CNEG [LANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [E-1:0]  r1_m  [LANES];
    logic signed [PW-1:0] r2_pa [LANES];
    logic signed [PW-1:0] r2_pb [LANES];
    logic signed [E-1:0]  r2_m0 [3];
    logic signed [CW-1:0] n3_c  [LANES];
    logic signed [CW-1:0] r3_c  [LANES];
    logic signed [E-1:0]  r3_m0 [3];
    logic signed [DW-1:0] r4_t  [3];
    logic signed [CW-1:0] r4_c  [LANES];
    logic signed [DW-1:0] r5_det;
    logic signed [CW-1:0] r5_c  [LANES];
    logic [CW-1:0]        n6_mag [LANES];
    t_ctl                 r6_ctl;
    logic [NW-1:0]        r6_num [LANES];
    logic                 r6_neg [LANES];
    logic [DW-1:0]        r6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_ctl <= '0;
        end else if (i_en) begin
            r1_v         <= i_valid;
            r2_v         <= r1_v;
            r3_v         <= r2_v;
            r4_v         <= r3_v;
            r5_v         <= r4_v;
            r6_ctl.valid <= r5_v;
            r6_ctl.singular <= (r5_det == '0);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n3_c[l] = CW'(r2_pa[l]) - CW'(r2_pb[l]);
            if (CNEG[l]) begin
                n3_c[l] = -n3_c[l];
            end
            n6_mag[l] = r5_c[l][CW-1] ? CW'(-r5_c[l]) : CW'(r5_c[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r1_m[l]   <= i_a[l][E-1:0];
                r2_pa[l]  <= PW'(r1_m[PA[l]]) * PW'(r1_m[PB[l]]);
                r2_pb[l]  <= PW'(r1_m[PC[l]]) * PW'(r1_m[PD[l]]);
                r3_c[l]   <= n3_c[l];
                r4_c[l]   <= r3_c[l];
                r5_c[l]   <= r4_c[l];
                r6_num[l] <= NW'(n6_mag[l]) << FRAC_BITS;
                r6_neg[l] <= r5_c[l][CW-1] ^ r5_det[DW-1];
            end
            for (int j = 0; j < 3; j++) begin
                r2_m0[j] <= r1_m[j];
                r3_m0[j] <= r2_m0[j];
                // expansion along the first row
                r4_t[j]  <= DW'(r3_m0[j]) * DW'(r3_c[3 * j]);
            end
            r5_det <= r4_t[0] + r4_t[1] + r4_t[2];
            r6_den <= r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
        end
    end

    assign o_ctl = r6_ctl;
    assign o_num = r6_num;
    assign o_neg = r6_neg;
    assign o_den = r6_den;

endmodule

@@ hdl/mi3_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, nine lanes.
module mi3_divider #(
    parameter int ELEM_BITS = mi3_pkg::DEF_ELEM_BITS,
    parameter int FRAC_BITS = mi3_pkg::DEF_FRAC_BITS,
    localparam int NW = 2 * ELEM_BITS + 1 + FRAC_BITS,
    localparam int DW = 3 * ELEM_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  mi3_pkg::t_ctl i_ctl,
    input  logic [NW-1:0] i_num [mi3_pkg::LANES],
    input  logic          i_neg [mi3_pkg::LANES],
    input  logic [DW-1:0] i_den,
    output mi3_pkg::t_ctl o_ctl,
    output logic [NW-1:0] o_quo [mi3_pkg::LANES],
    output logic          o_neg [mi3_pkg::LANES]
);
    import mi3_pkg::*;

    t_ctl          r_ctl [NW];
    logic [DW-1:0] r_den [NW];
    logic [DW-1:0] r_rem [NW-1][LANES];
    logic [NW-1:0] r_num [NW][LANES];
    logic          r_neg [NW][LANES];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        t_ctl          ctl_in;
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in [LANES];
        logic [NW-1:0] num_in [LANES];
        logic          neg_in [LANES];
        logic [DW-1:0] n_rem  [LANES];
        logic [NW-1:0] n_num  [LANES];

        if (s == 0) begin : g_first
            assign ctl_in = i_ctl;
            assign den_in = i_den;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = '0;
                assign num_in[l] = i_num[l];
                assign neg_in[l] = i_neg[l];
            end
        end else begin : g_next
            assign ctl_in = r_ctl[s-1];
            assign den_in = r_den[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = r_rem[s-1][l];
                assign num_in[l] = r_num[s-1][l];
                assign neg_in[l] = r_neg[s-1][l];
            end
        end

        // quotient bits shift in at the bottom as dividend bits leave the top
        always_comb begin
            logic [DW:0] t;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                t        = {rem_in[l], num_in[l][NW-1]};
                ge       = (t >= {1'b0, den_in});
                n_rem[l] = ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
                n_num[l] = {num_in[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else if (i_en) begin
                r_ctl[s] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                for (int l = 0; l < LANES; l++) begin
                    r_num[s][l] <= n_num[l];
                    r_neg[s][l] <= neg_in[l];
                end
            end
        end

        if (s < NW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_rem[s][l] <= n_rem[l];
                    end
                end
            end
        end
    end

    assign o_ctl = r_ctl[NW-1];
    assign o_quo = r_num[NW-1];
    assign o_neg = r_neg[NW-1];

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the pipelined 3x3 matrix inverse.
module tb;

    import mi3_pkg::*;

    localparam int LATENCY   = 2 * DEF_ELEM_BITS + DEF_FRAC_BITS + 8;
    localparam int IDLE_LIM  = 20000;
    localparam int N_RANDOM  = 1800;

    typedef logic signed [IN_W-1:0]  t_elem;
    typedef logic signed [OUT_W-1:0] t_entry;

    typedef struct {
        t_entry inv [LANES];
        logic   singular;
    } t_inverse;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic          i_ready = 1'b0;
    logic          o_valid;
    t_elem         a [LANES];
    logic [OUT_W-1:0] o_inv [LANES];
    logic          o_singular;

    t_inverse      inverse_q[$];
    int            n_errors = 0;
    int            idle_cycles = 0;
    bit            quiet_rx = 1'b0;  // stretch with the receiver never stalling
    bit            quiet_tx = 1'b0;

    initial for (int k = 0; k < LANES; k++) a[k] = '0;

    always #5 i_clk = ~i_clk;

    matrix3x3_inverse u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_a11      (a[0]), .i_a12 (a[1]), .i_a13 (a[2]),
        .i_a21      (a[3]), .i_a22 (a[4]), .i_a23 (a[5]),
        .i_a31      (a[6]), .i_a32 (a[7]), .i_a33 (a[8]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_inv11    (o_inv[0]), .o_inv12 (o_inv[1]), .o_inv13 (o_inv[2]),
        .o_inv21    (o_inv[3]), .o_inv22 (o_inv[4]), .o_inv23 (o_inv[5]),
        .o_inv31    (o_inv[6]), .o_inv32 (o_inv[7]), .o_inv33 (o_inv[8]),
        .o_singular (o_singular)
    );

    // Adjugate over the determinant, Q.16, truncated toward zero.
    function automatic t_inverse invert_matrix(input t_elem e [LANES]);
        longint   m [3][3];
        longint   adj [3][3];
        longint   det;
        longint   q;
        t_inverse r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = longint'(e[i*3+j]);
        det = m[0][0]*m[1][1]*m[2][2] + m[0][1]*m[1][2]*m[2][0]
            + m[1][0]*m[2][1]*m[0][2] - m[2][0]*m[1][1]*m[0][2]
            - m[0][1]*m[1][0]*m[2][2] - m[1][2]*m[2][1]*m[0][0];
        adj[0][0] =   m[1][1]*m[2][2] - m[1][2]*m[2][1];
        adj[0][1] = -(m[0][1]*m[2][2] - m[0][2]*m[2][1]);
        adj[0][2] =   m[0][1]*m[1][2] - m[0][2]*m[1][1];
        adj[1][0] = -(m[1][0]*m[2][2] - m[1][2]*m[2][0]);
        adj[1][1] =   m[0][0]*m[2][2] - m[0][2]*m[2][0];
        adj[1][2] = -(m[0][0]*m[1][2] - m[0][2]*m[1][0]);
        adj[2][0] =   m[1][0]*m[2][1] - m[1][1]*m[2][0];
        adj[2][1] = -(m[0][0]*m[2][1] - m[0][1]*m[2][0]);
        adj[2][2] =   m[0][0]*m[1][1] - m[0][1]*m[1][0];
        r.singular = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                if (det == 0) begin
                    q = 0;
                end else begin
                    q = (adj[i][j] * (64'sd1 <<< DEF_FRAC_BITS)) / det;
                end
                // clamp kept to mirror the safety saturation
                if (q > 64'sh0000_7FFF_FFFF_FFFF) q = 64'sh0000_7FFF_FFFF_FFFF;
                if (q < -64'sh0000_8000_0000_0000) q = -64'sh0000_8000_0000_0000;
                r.inv[i*3+j] = q[OUT_W-1:0];
            end
        return r;
    endfunction

    // Send one matrix; valid holds until accepted and stays up into the
    // next item unless a gap is drawn.
    task automatic send_matrix(input t_elem e [LANES]);
        while (!quiet_tx && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < LANES; k++) a[k] <= e[k];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        inverse_q.push_back(invert_matrix(e));
    endtask

    task automatic test_directed();
        t_elem e [LANES];
        t_elem corner [4] = '{16'sh7FFF, -16'sh8000, 16'sh0001, 16'shFFFF};
        // identity and its negation
        for (int k = 0; k < LANES; k++) e[k] = (k % 4 == 0) ? 16'sd1 : 16'sd0;
        send_matrix(e);
        for (int k = 0; k < LANES; k++) e[k] = (k % 4 == 0) ? -16'sd1 : 16'sd0;
        send_matrix(e);
        // all zero, all equal extremes: singular
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < LANES; k++) e[k] = corner[c];
            send_matrix(e);
        end
        for (int k = 0; k < LANES; k++) e[k] = '0;
        send_matrix(e);
        // diagonal extremes give the largest and smallest entries
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < LANES; k++) e[k] = (k % 4 == 0) ? corner[c] : 16'sd0;
            send_matrix(e);
        end
        // extreme off-diagonal mixes, permutation, near-singular
        e = '{-16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, -16'sh8000};
        send_matrix(e);
        e = '{16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, -16'sh8000,
              16'sh7FFF, 16'sd0, 16'sd0};
        send_matrix(e);
        e = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd10};
        send_matrix(e);
        e = '{16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd7};
        send_matrix(e);
    endtask

    task automatic test_random();
        t_elem e [LANES];
        int    mode;
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_tx = (n >= 600 && n < 800);
            mode = $urandom_range(9);
            for (int k = 0; k < LANES; k++) begin
                case (mode)
                    0, 1, 2, 3: e[k] = t_elem'($urandom);
                    4, 5:       e[k] = t_elem'($urandom_range(15)) - 16'sd8;
                    6:          e[k] = ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000;
                    default:    e[k] = t_elem'($urandom_range(511)) - 16'sd256;
                endcase
            end
            // make some singular on purpose: copy a row
            if (mode == 9 || mode == 5)
                for (int k = 0; k < 3; k++) e[6+k] = e[($urandom_range(1))*3+k];
            send_matrix(e);
        end
        quiet_tx = 1'b0;
    endtask

    // Receiver: random stall with a quiet stretch in the middle of the run.
    always @(posedge i_clk) begin
        i_ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_inverse exp_inv;
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got singular=%0b",
                         $time, o_singular);
                n_errors++;
            end else begin
                exp_inv = inverse_q.pop_front();
                for (int k = 0; k < LANES; k++)
                    if (o_inv[k] !== exp_inv.inv[k]) begin
                        $display("%0t: inv[%0d] expected %0d actual %0d", $time, k,
                                 exp_inv.inv[k], $signed(o_inv[k]));
                        n_errors++;
                    end
                if (o_singular !== exp_inv.singular) begin
                    $display("%0t: singular expected %0b actual %0b", $time,
                             exp_inv.singular, o_singular);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        quiet_rx = 1'b1;
        test_random();
        i_valid <= 1'b0;
        wait (inverse_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && inverse_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // release the receiver's quiet stretch after a while
    initial begin
        wait (quiet_rx);
        repeat (1500) @(posedge i_clk);
        quiet_rx = 1'b0;
    end

endmodule

@@ matrix3x3_inverse.f @@
hdl/mi3_pkg.sv
hdl/mi3_front.sv
hdl/mi3_divider.sv
hdl/matrix3x3_inverse.sv
tb/tb.sv
